// ===== rtl/core/indexed_list_engine_defines.svh =====
// Assertion macros for the indexed list engine.
// Included by the modules that carry concurrent checks; no other dependency.
`ifndef INDEXED_LIST_ENGINE_DEFINES_SVH
`define INDEXED_LIST_ENGINE_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk and switched off during reset.
`define ILE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, sampled on clk and switched off during reset.
`define ILE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ILE_ASSERT_IMP(lbl, ante, cons, msg)
`define ILE_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/core/ile_pkg.sv =====
// Shared types and constants of the indexed list engine.
// Used by ile_cell, ile_ctrl and indexed_list_engine; depends on nothing.
package ile_pkg;

  // Field widths of the stream payloads.
  localparam int DATA_W  = 32;
  localparam int POS_W   = 9;
  localparam int COUNT_W = 9;
  localparam int MODE_W  = 3;
  // Cell index width; covers every position up to the largest capacity.
  localparam int IDX_W   = 13;

  // Command codes carried in the mode field.
  typedef enum logic [MODE_W-1:0] {
    MODE_READ   = 3'd0,
    MODE_FRONT  = 3'd1,
    MODE_BACK   = 3'd2,
    MODE_AT     = 3'd3,
    MODE_DELETE = 3'd4
  } mode_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Operation broadcast to every cell of the chain.
  typedef enum logic [2:0] {
    CELL_HOLD   = 3'd0,
    CELL_INSERT = 3'd1,
    CELL_DELETE = 3'd2,
    CELL_LOAD   = 3'd3,
    CELL_SHIFT  = 3'd4
  } cell_op_t;

  // Controller state.
  typedef enum logic {
    S_IDLE = 1'b0,
    S_READ = 1'b1
  } state_t;

  // Command from the controller to the cells.
  typedef struct packed {
    cell_op_t          op;
    logic [IDX_W-1:0]  pos;
    logic [DATA_W-1:0] value;
  } cell_cmd_t;

endpackage

// ===== rtl/core/indexed_list_engine.sv =====
// Top level of the indexed list engine: a chain of storage cells and its controller.
// Depends on ile_pkg, ile_cell and ile_ctrl.

// The engine keeps an ordered list of up to CAPACITY signed 32-bit values, one per
// cell of a chain, and returns one result beat for every command beat. Insert,
// append, positional insert and delete move all later cells by one place
// together, so these commands, bad reads and refused commands load their result
// directly, and a new command is taken every cycle while no read is in progress
// and the result side keeps up. A good read at position p copies every cell's
// entry into a read chain that then moves one cell per cycle toward cell 0, where
// the value is taken. No clearing pass follows reset; the list starts empty. The
// count in each result is the number of values held, kept to its low 9 bits.
module indexed_list_engine #(
  parameter int CAPACITY = 256
) (
  input  logic        clk,
  input  logic        rst,
  // s_tdata fields from bit 0: mode[2:0], position[11:3], item_value[43:12], zeros.
  input  logic [47:0] s_tdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  // m_tdata fields from bit 0: read_value[31:0], status[33:32], count[42:34], zeros.
  output logic [47:0] m_tdata,
  output logic        m_tvalid,
  input  logic        m_tready
);

  localparam int DW = ile_pkg::DATA_W;

  ile_pkg::cell_cmd_t          cmd;
  logic [DW-1:0]               entry [CAPACITY];
  logic [DW-1:0]               rbus  [CAPACITY];
  logic [DW-1:0]               read_value;
  logic [1:0]                  status;
  logic [ile_pkg::COUNT_W-1:0] count;

  // Controller: decodes commands, keeps the count and holds the result beat.
  ile_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .mode       (s_tdata[2:0]),
    .position   (s_tdata[11:3]),
    .item_value (s_tdata[43:12]),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .read_value (read_value),
    .status     (status),
    .count      (count),
    .rbus0      (rbus[0]),
    .cmd        (cmd)
  );

  // Chain of cells; each sees its lower and upper neighbor.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DW-1:0] lower_entry;
    logic [DW-1:0] upper_entry;
    logic [DW-1:0] upper_rbus;

    if (i == 0) begin : g_first
      assign lower_entry = '0;
    end else begin : g_lower
      assign lower_entry = entry[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign upper_entry = '0;
      assign upper_rbus  = '0;
    end else begin : g_upper
      assign upper_entry = entry[i+1];
      assign upper_rbus  = rbus[i+1];
    end

    ile_cell #(
      .INDEX (i)
    ) u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .lower_entry (lower_entry),
      .upper_entry (upper_entry),
      .upper_rbus  (upper_rbus),
      .entry       (entry[i]),
      .rbus        (rbus[i])
    );
  end

  // Result beat packing.
  assign m_tdata = {5'b0, count, status, read_value};

endmodule

// ===== rtl/core/ile_cell.sv =====
// One storage cell of the list chain: holds one entry and one read-chain stage.
// Depends on ile_pkg for the command struct and widths.
module ile_cell #(
  parameter int INDEX = 0
) (
  input  logic                       clk,
  input  ile_pkg::cell_cmd_t         cmd,
  input  logic [ile_pkg::DATA_W-1:0] lower_entry,
  input  logic [ile_pkg::DATA_W-1:0] upper_entry,
  input  logic [ile_pkg::DATA_W-1:0] upper_rbus,
  output logic [ile_pkg::DATA_W-1:0] entry,
  output logic [ile_pkg::DATA_W-1:0] rbus
);

  localparam int IW = ile_pkg::IDX_W;
  localparam logic [IW-1:0] IDX = IW'(INDEX);

  // Entry moves up on insert and down on delete; the read chain moves toward cell 0.
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      ile_pkg::CELL_INSERT: begin
        if (IDX > cmd.pos) begin
          entry <= lower_entry;
        end else if (IDX == cmd.pos) begin
          entry <= cmd.value;
        end
      end
      ile_pkg::CELL_DELETE: begin
        if (IDX >= cmd.pos) begin
          entry <= upper_entry;
        end
      end
      ile_pkg::CELL_LOAD: begin
        rbus <= entry;
      end
      ile_pkg::CELL_SHIFT: begin
        rbus <= upper_rbus;
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== rtl/core/ile_ctrl.sv =====
// Command decoder, fill count and result register of the indexed list engine.
// Depends on ile_pkg and on indexed_list_engine_defines.svh for its checks.
`include "indexed_list_engine_defines.svh"

module ile_ctrl #(
  parameter int CAPACITY = 256
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [ile_pkg::MODE_W-1:0]  mode,
  input  logic [ile_pkg::POS_W-1:0]   position,
  input  logic [ile_pkg::DATA_W-1:0]  item_value,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [ile_pkg::DATA_W-1:0]  read_value,
  output logic [1:0]                  status,
  output logic [ile_pkg::COUNT_W-1:0] count,
  input  logic [ile_pkg::DATA_W-1:0]  rbus0,
  output ile_pkg::cell_cmd_t          cmd
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = ile_pkg::IDX_W;
  localparam int OW = ile_pkg::COUNT_W;
  localparam int PW = ile_pkg::POS_W;
  localparam int DW = ile_pkg::DATA_W;

  ile_pkg::state_t  state;
  ile_pkg::state_t  state_next;
  logic [CW-1:0]    fill_count;
  logic [CW-1:0]    count_next;
  logic [PW-1:0]    rd_cnt;
  logic [IW-1:0]    pos_ext;
  logic [IW-1:0]    count_ext;
  logic [IW-1:0]    op_pos;
  logic             full;
  logic             accept;
  logic             out_free;
  logic             out_load;
  logic             do_insert;
  logic             do_delete;
  logic             start_read;
  logic [DW-1:0]    res_value;
  ile_pkg::status_t res_status;

  assign pos_ext   = IW'(position);
  assign count_ext = IW'(fill_count);
  assign full      = (fill_count == CW'(CAPACITY));
  assign out_free  = !m_tvalid || m_tready;
  assign accept    = s_tvalid && s_tready;

  // Decode the command against the current fill count.
  always_comb begin
    do_insert  = 1'b0;
    do_delete  = 1'b0;
    start_read = 1'b0;
    op_pos     = pos_ext;
    res_value  = '0;
    res_status = ile_pkg::ST_DONE;
    unique case (ile_pkg::mode_t'(mode))
      ile_pkg::MODE_READ: begin
        if (pos_ext < count_ext) begin
          start_read = 1'b1;
        end else begin
          res_value  = '1;
          res_status = ile_pkg::ST_RANGE;
        end
      end
      ile_pkg::MODE_FRONT: begin
        op_pos = '0;
        if (full) begin
          res_status = ile_pkg::ST_FULL;
        end else begin
          do_insert = 1'b1;
        end
      end
      ile_pkg::MODE_BACK: begin
        op_pos = count_ext;
        if (full) begin
          res_status = ile_pkg::ST_FULL;
        end else begin
          do_insert = 1'b1;
        end
      end
      ile_pkg::MODE_AT: begin
        if (pos_ext > count_ext) begin
          res_status = ile_pkg::ST_RANGE;
        end else if (full) begin
          res_status = ile_pkg::ST_FULL;
        end else begin
          do_insert = 1'b1;
        end
      end
      ile_pkg::MODE_DELETE: begin
        if (pos_ext >= count_ext) begin
          res_status = ile_pkg::ST_RANGE;
        end else begin
          do_delete = 1'b1;
        end
      end
      default: begin
        res_status = ile_pkg::ST_RANGE;
      end
    endcase
  end

  // Fill count after this beat.
  always_comb begin
    count_next = fill_count;
    if (accept && do_insert) begin
      count_next = fill_count + CW'(1);
    end else if (accept && do_delete) begin
      count_next = fill_count - CW'(1);
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ile_pkg::S_IDLE: begin
        if (accept && start_read) begin
          state_next = ile_pkg::S_READ;
        end
      end
      ile_pkg::S_READ: begin
        if (rd_cnt == '0 && out_free) begin
          state_next = ile_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = ile_pkg::S_IDLE;
      end
    endcase
  end

  // State outputs: input ready, cell command and result load.
  always_comb begin
    s_tready  = 1'b0;
    out_load  = 1'b0;
    cmd.op    = ile_pkg::CELL_HOLD;
    cmd.pos   = op_pos;
    cmd.value = item_value;
    unique case (state)
      ile_pkg::S_IDLE: begin
        s_tready = out_free;
        if (s_tvalid && out_free) begin
          out_load = !start_read;
          if (do_insert) begin
            cmd.op = ile_pkg::CELL_INSERT;
          end else if (do_delete) begin
            cmd.op = ile_pkg::CELL_DELETE;
          end else if (start_read) begin
            cmd.op = ile_pkg::CELL_LOAD;
          end
        end
      end
      ile_pkg::S_READ: begin
        if (rd_cnt != '0) begin
          cmd.op = ile_pkg::CELL_SHIFT;
        end else begin
          out_load = out_free;
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ile_pkg::S_IDLE;
      fill_count <= '0;
      rd_cnt     <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      state      <= state_next;
      fill_count <= count_next;
      if (accept && start_read) begin
        rd_cnt <= position;
      end else if (state == ile_pkg::S_READ && rd_cnt != '0) begin
        rd_cnt <= rd_cnt - PW'(1);
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    if (out_load) begin
      if (state == ile_pkg::S_IDLE) begin
        read_value <= res_value;
        status     <= res_status;
        count      <= OW'(count_next);
      end else begin
        read_value <= rbus0;
        status     <= ile_pkg::ST_DONE;
        count      <= OW'(fill_count);
      end
    end
  end

  // Checks on the controller.
  `ILE_ASSERT_IMP(a_count_bound, 1'b1, fill_count <= CW'(CAPACITY), "fill count above capacity")
  `ILE_ASSERT_NXT(a_read_start, accept && start_read, state == ile_pkg::S_READ, "read not started")
  `ILE_ASSERT_IMP(a_read_slot, state == ile_pkg::S_READ, !m_tvalid, "result slot busy in read")
  `ILE_ASSERT_NXT(a_full_hold, accept && full && !do_delete, fill_count == $past(fill_count), "insert when full")

endmodule
